// ----- src/msd_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// msd_pkg: shared types and codes for the multiset store
// Operation codes, decoded operation type and the command word that passes
// from the front end to the back end.
// ----------------------------------------------------------------------------
package msd_pkg;

    localparam int DATA_W = 32;
    localparam int FUNC_W = 3;

    localparam logic [FUNC_W-1:0] FN_ADD    = 3'd0;
    localparam logic [FUNC_W-1:0] FN_DEL    = 3'd1;
    localparam logic [FUNC_W-1:0] FN_COUNT  = 3'd2;
    localparam logic [FUNC_W-1:0] FN_EXISTS = 3'd3;
    localparam logic [FUNC_W-1:0] FN_DUMP   = 3'd4;

    typedef enum logic [2:0] {
        OP_ADD,
        OP_DEL,
        OP_COUNT,
        OP_EXISTS,
        OP_DUMP,
        OP_NOP
    } t_op;

    typedef struct packed {
        t_op                      op;
        logic signed [DATA_W-1:0] operand;
    } t_cmd;

endpackage
`default_nettype wire

// ----- src/msd_front.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// msd_front: input decode and command queue
// Accepts input words, decodes the function code and holds up to two
// commands for the back end.
// ----------------------------------------------------------------------------
module msd_front (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_s_tvalid,
    output logic                             o_s_tready,
    input  wire logic [msd_pkg::DATA_W-1:0]  i_s_tdata,   // operand
    input  wire logic [msd_pkg::FUNC_W-1:0]  i_s_tuser,   // func
    output logic                             o_cmd_valid,
    output msd_pkg::t_cmd                    o_cmd,
    input  wire logic                        i_cmd_pop
);

    msd_pkg::t_cmd r_q [2];
    logic          r_wp;
    logic          r_rp;
    logic [1:0]    r_cnt;
    logic          push;
    msd_pkg::t_cmd dec;

    always_comb begin
        dec.operand = $signed(i_s_tdata);
        case (i_s_tuser)
            msd_pkg::FN_ADD:    dec.op = msd_pkg::OP_ADD;
            msd_pkg::FN_DEL:    dec.op = msd_pkg::OP_DEL;
            msd_pkg::FN_COUNT:  dec.op = msd_pkg::OP_COUNT;
            msd_pkg::FN_EXISTS: dec.op = msd_pkg::OP_EXISTS;
            msd_pkg::FN_DUMP:   dec.op = msd_pkg::OP_DUMP;
            default:            dec.op = msd_pkg::OP_NOP;
        endcase
    end

    assign o_s_tready  = (r_cnt != 2'd2);
    assign push        = i_s_tvalid && o_s_tready;
    assign o_cmd_valid = (r_cnt != 2'd0);
    assign o_cmd       = r_q[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push) begin
                r_wp <= ~r_wp;
            end
            if (i_cmd_pop) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + 2'(push) - 2'(i_cmd_pop);
        end
        if (push) begin
            r_q[r_wp] <= dec;
        end
    end

`ifndef SYNTH
    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= 2'd2)
        else $error("queue overfilled");
    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd_pop |-> r_cnt != 2'd0)
        else $error("pop from empty queue");
    a_push_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (push && !i_cmd_pop) |=> r_cnt == $past(r_cnt) + 2'd1)
        else $error("queue count lost a push");
`endif

endmodule
`default_nettype wire

// ----- src/msd_back.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// msd_back: store engine
// Holds the entries in a single-port-read memory, walks it for lookups,
// delete compaction and selection-sort dumps, and drives the result register.
// ----------------------------------------------------------------------------
module msd_back #(
    parameter int CAPACITY = 16,
    parameter int CW       = $clog2(CAPACITY + 1),
    parameter int IW       = $clog2(CAPACITY)
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_cmd_valid,
    input  wire msd_pkg::t_cmd                     i_cmd,
    output logic                                   o_cmd_pop,
    input  wire logic                              i_m_tready,
    output logic                                   o_m_tvalid,
    output logic                                   o_ok,
    output logic [CW-1:0]                          o_match_count,
    output logic [CW-1:0]                          o_stored_count,
    output logic signed [msd_pkg::DATA_W-1:0]      o_dump_value,
    output logic                                   o_last
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_SHIFT,
        S_EMIT
    } t_state;

    logic signed [msd_pkg::DATA_W-1:0] r_mem [CAPACITY];
    logic signed [msd_pkg::DATA_W-1:0] r_rdata;
    logic                              mem_we;
    logic [IW-1:0]                     mem_waddr;
    logic signed [msd_pkg::DATA_W-1:0] mem_wdata;
    logic [IW-1:0]                     mem_raddr;

    t_state                            r_state,     n_state;
    logic [CW-1:0]                     r_fill,      n_fill;
    logic [CW-1:0]                     r_idx,       n_idx;
    logic                              r_cv,        n_cv;
    logic [CW-1:0]                     r_cidx,      n_cidx;
    logic [CW-1:0]                     r_cnt,       n_cnt;
    logic [CW-1:0]                     r_outn,      n_outn;
    logic                              r_have_best, n_have_best;
    logic signed [msd_pkg::DATA_W-1:0] r_best,      n_best;
    logic [CW-1:0]                     r_best_idx,  n_best_idx;
    logic                              r_have_prev, n_have_prev;
    logic signed [msd_pkg::DATA_W-1:0] r_prev,      n_prev;
    logic [CW-1:0]                     r_prev_idx,  n_prev_idx;
    logic                              r_res_ok,    n_res_ok;
    logic [CW-1:0]                     r_res_cnt,   n_res_cnt;
    logic signed [msd_pkg::DATA_W-1:0] r_res_val,   n_res_val;
    logic                              r_res_last,  n_res_last;
    logic                              r_ovalid,    n_ovalid;
    logic                              r_o_ok;
    logic [CW-1:0]                     r_o_mcnt;
    logic [CW-1:0]                     r_o_stored;
    logic signed [msd_pkg::DATA_W-1:0] r_o_val;
    logic                              r_o_last;

    logic          can_emit;
    logic          load_out;
    logic          issue;
    logic          eq;
    logic          after_prev;
    logic          better;
    logic          done;
    logic [CW-1:0] cidx_m1;

    assign can_emit   = !r_ovalid || i_m_tready;
    assign issue      = (r_idx < r_fill);
    assign eq         = (r_rdata == i_cmd.operand);
    assign done       = !issue && !r_cv;
    assign cidx_m1    = r_cidx - CW'(1);
    assign after_prev = !r_have_prev || (r_rdata > r_prev) ||
                        ((r_rdata == r_prev) && (r_cidx > r_prev_idx));
    assign better     = after_prev && (!r_have_best || (r_rdata < r_best));

    always_comb begin
        n_state     = r_state;
        n_fill      = r_fill;
        n_idx       = r_idx;
        n_cv        = r_cv;
        n_cidx      = r_cidx;
        n_cnt       = r_cnt;
        n_outn      = r_outn;
        n_have_best = r_have_best;
        n_best      = r_best;
        n_best_idx  = r_best_idx;
        n_have_prev = r_have_prev;
        n_prev      = r_prev;
        n_prev_idx  = r_prev_idx;
        n_res_ok    = r_res_ok;
        n_res_cnt   = r_res_cnt;
        n_res_val   = r_res_val;
        n_res_last  = r_res_last;
        n_ovalid    = r_ovalid && !i_m_tready;
        load_out    = 1'b0;
        o_cmd_pop   = 1'b0;
        mem_we      = 1'b0;
        mem_waddr   = r_fill[IW-1:0];
        mem_wdata   = i_cmd.operand;
        mem_raddr   = r_idx[IW-1:0];

        case (r_state)
            S_IDLE: begin
                if (i_cmd_valid) begin
                    n_res_ok    = 1'b0;
                    n_res_cnt   = '0;
                    n_res_val   = '0;
                    n_res_last  = 1'b1;
                    n_idx       = '0;
                    n_cv        = 1'b0;
                    n_cnt       = '0;
                    n_outn      = '0;
                    n_have_best = 1'b0;
                    n_have_prev = 1'b0;
                    case (i_cmd.op)
                        msd_pkg::OP_ADD: begin
                            if (r_fill < CW'(CAPACITY)) begin
                                mem_we   = 1'b1;
                                n_fill   = r_fill + CW'(1);
                                n_res_ok = 1'b1;
                            end
                            n_state = S_EMIT;
                        end
                        msd_pkg::OP_DEL, msd_pkg::OP_COUNT, msd_pkg::OP_EXISTS: begin
                            n_state = S_SCAN;
                        end
                        msd_pkg::OP_DUMP: begin
                            n_state = (r_fill == '0) ? S_EMIT : S_SCAN;
                        end
                        default: begin
                            n_state = S_EMIT;
                        end
                    endcase
                end
            end
            S_SCAN: begin
                n_idx  = r_idx + CW'(issue);
                n_cv   = issue;
                n_cidx = r_idx;
                if (i_cmd.op == msd_pkg::OP_DEL && r_cv && eq) begin
                    n_idx   = r_cidx + CW'(1);
                    n_cv    = 1'b0;
                    n_state = S_SHIFT;
                end else if (done) begin
                    n_state = S_EMIT;
                    case (i_cmd.op)
                        msd_pkg::OP_COUNT:  n_res_cnt = r_cnt;
                        msd_pkg::OP_EXISTS: n_res_ok  = (r_cnt != '0);
                        msd_pkg::OP_DUMP: begin
                            n_res_ok   = 1'b1;
                            n_res_val  = r_best;
                            n_res_last = ((r_outn + CW'(1)) == r_fill);
                        end
                        default:            n_res_ok  = 1'b0;
                    endcase
                end else if (r_cv) begin
                    n_cnt = r_cnt + CW'(eq);
                    if (better) begin
                        n_have_best = 1'b1;
                        n_best      = r_rdata;
                        n_best_idx  = r_cidx;
                    end
                end
            end
            S_SHIFT: begin
                n_idx  = r_idx + CW'(issue);
                n_cv   = issue;
                n_cidx = r_idx;
                if (r_cv) begin
                    mem_we    = 1'b1;
                    mem_waddr = cidx_m1[IW-1:0];
                    mem_wdata = r_rdata;
                end
                if (done) begin
                    n_fill   = r_fill - CW'(1);
                    n_res_ok = 1'b1;
                    n_state  = S_EMIT;
                end
            end
            S_EMIT: begin
                if (can_emit) begin
                    n_ovalid = 1'b1;
                    load_out = 1'b1;
                    if (i_cmd.op == msd_pkg::OP_DUMP && !r_res_last) begin
                        n_outn      = r_outn + CW'(1);
                        n_prev      = r_best;
                        n_prev_idx  = r_best_idx;
                        n_have_prev = 1'b1;
                        n_have_best = 1'b0;
                        n_idx       = '0;
                        n_cv        = 1'b0;
                        n_state     = S_SCAN;
                    end else begin
                        o_cmd_pop = 1'b1;
                        n_state   = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
        r_rdata <= r_mem[mem_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_fill      <= '0;
            r_idx       <= '0;
            r_cv        <= 1'b0;
            r_have_best <= 1'b0;
            r_have_prev <= 1'b0;
            r_ovalid    <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_fill      <= n_fill;
            r_idx       <= n_idx;
            r_cv        <= n_cv;
            r_have_best <= n_have_best;
            r_have_prev <= n_have_prev;
            r_ovalid    <= n_ovalid;
        end
        r_cidx     <= n_cidx;
        r_cnt      <= n_cnt;
        r_outn     <= n_outn;
        r_best     <= n_best;
        r_best_idx <= n_best_idx;
        r_prev     <= n_prev;
        r_prev_idx <= n_prev_idx;
        r_res_ok   <= n_res_ok;
        r_res_cnt  <= n_res_cnt;
        r_res_val  <= n_res_val;
        r_res_last <= n_res_last;
        if (load_out) begin
            r_o_ok     <= r_res_ok;
            r_o_mcnt   <= r_res_cnt;
            r_o_stored <= r_fill;
            r_o_val    <= r_res_val;
            r_o_last   <= r_res_last;
        end
    end

    assign o_m_tvalid     = r_ovalid;
    assign o_ok           = r_o_ok;
    assign o_match_count  = r_o_mcnt;
    assign o_stored_count = r_o_stored;
    assign o_dump_value   = r_o_val;
    assign o_last         = r_o_last;

`ifndef SYNTH
    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= CW'(CAPACITY))
        else $error("fill level above capacity");
    a_fill_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_fill != $past(r_fill)) |->
            (($past(r_state) == S_IDLE && $past(i_cmd.op) == msd_pkg::OP_ADD) ||
             $past(r_state) == S_SHIFT))
        else $error("fill level changed outside add or delete");
    a_scan_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN || r_state == S_SHIFT) |-> r_idx <= r_fill)
        else $error("walk pointer beyond stored entries");
    a_pop_with_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd_pop |-> (i_cmd_valid && r_state == S_EMIT))
        else $error("command retired without one pending");
`endif

endmodule
`default_nettype wire

// ----- src/multiset_store_with_sorted_dump.sv -----
`timescale 1ns / 1ps
`default_nettype none
// Add, unused codes and an empty dump go straight to the result register; count, exists
// and delete walk the stored entries first, and a found delete shifts the later entries down.
// Dump: each result is a full pass over the store through the single read port of the
// entry memory.
// The engine takes the next queued word the cycle after it retires one; the queue holds
// the running command and one more. Reset empties store and queue; memory is not cleared.
// ----------------------------------------------------------------------------
// multiset_store_with_sorted_dump: bounded multiset with sorted readout
// Streaming front end and queue feeding a memory-walking store engine.
// ----------------------------------------------------------------------------
module multiset_store_with_sorted_dump #(
    parameter int CAPACITY = 16
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    input  wire logic [31:0]                   s_tdata,   // operand
    input  wire logic [2:0]                    s_tuser,   // func
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    output logic [((2*$clog2(CAPACITY+1)+32+7)/8)*8-1:0] m_tdata,
    // match_count, stored_count, dump_value
    output logic                               m_tuser,   // ok
    output logic                               m_tlast
);

    localparam int CW    = $clog2(CAPACITY + 1);
    localparam int IW    = $clog2(CAPACITY);
    localparam int OUT_W = ((2 * CW + msd_pkg::DATA_W + 7) / 8) * 8;

    logic                              cmd_valid;
    msd_pkg::t_cmd                     cmd;
    logic                              cmd_pop;
    logic [CW-1:0]                     match_count;
    logic [CW-1:0]                     stored_count;
    logic signed [msd_pkg::DATA_W-1:0] dump_value;

    msd_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (s_tvalid),
        .o_s_tready  (s_tready),
        .i_s_tdata   (s_tdata),
        .i_s_tuser   (s_tuser),
        .o_cmd_valid (cmd_valid),
        .o_cmd       (cmd),
        .i_cmd_pop   (cmd_pop)
    );

    msd_back #(
        .CAPACITY (CAPACITY),
        .CW       (CW),
        .IW       (IW)
    ) u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd_valid    (cmd_valid),
        .i_cmd          (cmd),
        .o_cmd_pop      (cmd_pop),
        .i_m_tready     (m_tready),
        .o_m_tvalid     (m_tvalid),
        .o_ok           (m_tuser),
        .o_match_count  (match_count),
        .o_stored_count (stored_count),
        .o_dump_value   (dump_value),
        .o_last         (m_tlast)
    );

    assign m_tdata = OUT_W'({dump_value, stored_count, match_count});

endmodule
`default_nettype wire
